/* rtl/glzw_pkg.sv */
package glzw_pkg;

  localparam int MAX_CODE_WIDTH_DEF = 12;
  localparam logic [3:0] LIT_WIDTH_RESET = 4'd8;
  localparam logic [3:0] LIT_WIDTH_MIN = 4'd2;
  localparam logic [3:0] LIT_WIDTH_MAX = 4'd8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       string_end;
  } out_word_t;

endpackage

/* rtl/glzw_if.sv */
interface glzw_in_if;
  glzw_pkg::in_word_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface glzw_out_if;
  glzw_pkg::out_word_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/gif_lzw_decoder.sv */
// Channel   Dir  Word
// in_ch     in   in_byte[7:0], final_byte
// out_ch    out  out_byte[7:0], string_end
// cfg       in   cfg_we, cfg_data[3:0] (literal width)
//
// A word is taken only while the decoder is idle; its 8 bits then go in one
// per cycle, pausing while a completed code is decoded; after a stop code
// the rest of the input up to the final word is dropped. A completed code
// is walked in chain steps (read, then use) while suffixes go onto the stack
// memory, then each byte is popped to the output register (read, then pop).
// Pops stall while out_ch holds off. Reset (rst, synchronous) clears control
// state only; the dictionary and stack are undefined until written.
module gif_lzw_decoder
  import glzw_pkg::*;
#(
  parameter int MAX_CODE_WIDTH = MAX_CODE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  glzw_in_if.sink    in_ch,
  glzw_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);
  localparam int CW = MAX_CODE_WIDTH;
  localparam int DEPTH = 1 << CW;
  localparam int WW = $clog2(CW + 1);
  localparam int BW = $clog2(CW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BITS = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_PRD  = 3'd5;

  // Dictionary memory: {prefix, suffix}; stack memory
  logic [CW+7:0] dict [DEPTH];
  logic [7:0]    stack [DEPTH];
  logic [CW+7:0] dict_q;
  logic [7:0]    stack_q;

  logic [2:0]    state, state_next;
  logic [3:0]    lit_w, lit_w_next;
  logic [CW-1:0] bitbuf, bitbuf_next;
  logic [WW-1:0] bitcnt, bitcnt_next;
  logic [WW-1:0] code_w, code_w_next;
  logic [CW-1:0] prev_code, prev_code_next;
  logic          prev_valid, prev_valid_next;
  // first byte of the previous string
  logic [7:0]    prev_first, prev_first_next;
  logic [CW:0]   next_free, next_free_next;
  logic          stopped, stopped_next;
  logic [7:0]    cur_byte, cur_byte_next;
  logic          cur_final, cur_final_next;
  logic [2:0]    bit_idx, bit_idx_next;
  logic [CW-1:0] walk, walk_next;
  logic [CW:0]   sp, sp_next;
  // pending entry add waits for first byte of the code
  logic          add_pend, add_pend_next;
  logic          kwk, kwk_next;
  logic [CW-1:0] emit_code, emit_code_next;
  logic          ovalid, ovalid_next;
  out_word_t     odata, odata_next;
  logic          byte_end;

  logic [3:0]    cfg_lw;
  logic [CW:0]   clear_code;
  logic [CW-1:0] code_now;
  logic [WW-1:0] bitcnt_inc;

  assign cfg_lw = (cfg_data < LIT_WIDTH_MIN) ? LIT_WIDTH_MIN :
                  (cfg_data > LIT_WIDTH_MAX) ? LIT_WIDTH_MAX : cfg_data;
  assign clear_code = (CW+1)'(1) << lit_w;
  assign bitcnt_inc = bitcnt + WW'(1);
  always_comb begin
    code_now = bitbuf;
    code_now[bitcnt[BW-1:0]] = cur_byte[bit_idx];
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = ovalid;
  assign out_ch.data = odata;

  // Code classification
  logic room;
  logic code_done;
  logic is_clear;
  logic is_stop;
  logic is_known;
  logic walk_start;
  logic at_root;
  logic pop_fire;
  logic grow;
  assign room = next_free < (CW+1)'(DEPTH);
  assign code_done = (state == S_BITS) && !stopped && (bitcnt_inc >= code_w);
  assign is_clear = {1'b0, code_now} == clear_code;
  assign is_stop = {1'b0, code_now} == clear_code + (CW+1)'(1);
  assign is_known = {1'b0, code_now} < next_free;
  assign walk_start = code_done && !is_clear && !is_stop && (is_known || (prev_valid && room));
  assign at_root = (state == S_WALK) && ({1'b0, walk} < clear_code);
  assign pop_fire = (state == S_POP) && (!ovalid || out_ch.ready);
  assign grow = (next_free[CW-1:0] == CW'(((CW+1)'(1) << code_w) - (CW+1)'(1)))
                && (code_w < WW'(CW));

  // Memory ports
  logic          d_we;
  logic [CW-1:0] d_waddr;
  logic [CW+7:0] d_wdata;
  logic          s_we;
  logic [CW-1:0] s_addr;
  logic [7:0]    s_wdata;

  always_ff @(posedge clk) begin
    if (d_we) dict[d_waddr] <= d_wdata;
    dict_q <= dict[walk];
    if (s_we) stack[s_addr] <= s_wdata;
    stack_q <= stack[s_addr];
  end

  logic [CW-1:0] w_prefix;
  logic [7:0]    w_suffix;
  assign w_prefix = dict_q[CW+7:8];
  assign w_suffix = dict_q[7:0];

  // Memory control
  always_comb begin
    d_we = 1'b0;
    d_waddr = next_free[CW-1:0];
    d_wdata = '0;
    s_we = 1'b0;
    s_addr = sp[CW-1:0];
    s_wdata = w_suffix;
    if (state == S_WALK) begin
      s_we = 1'b1;
      if (at_root) begin
        s_wdata = walk[7:0];
        // add entry: previous string plus the root literal of this one
        if (add_pend) begin
          d_we = 1'b1;
          d_wdata = {prev_code, walk[7:0]};
        end
      end
    end else if (state == S_POP || state == S_PRD) begin
      s_addr = sp[CW-1:0] - CW'(1);
    end
  end

  // Next-state logic
  always_comb begin
    state_next = state;
    lit_w_next = lit_w;
    bitbuf_next = bitbuf;
    bitcnt_next = bitcnt;
    code_w_next = code_w;
    prev_code_next = prev_code;
    prev_valid_next = prev_valid;
    prev_first_next = prev_first;
    next_free_next = next_free;
    stopped_next = stopped;
    cur_byte_next = cur_byte;
    cur_final_next = cur_final;
    bit_idx_next = bit_idx;
    walk_next = walk;
    sp_next = sp;
    add_pend_next = add_pend;
    kwk_next = kwk;
    emit_code_next = emit_code;
    ovalid_next = ovalid && !out_ch.ready;
    odata_next = odata;
    byte_end = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          cur_byte_next = in_ch.data.in_byte;
          cur_final_next = in_ch.data.final_byte;
          bit_idx_next = '0;
          state_next = S_BITS;
        end
      end
      // Gather one bit per cycle
      S_BITS: begin
        if (code_done) begin
          bitbuf_next = '0;
          bitcnt_next = '0;
          if (is_clear) begin
            code_w_next = WW'(lit_w) + WW'(1);
            prev_code_next = '0;
            prev_valid_next = 1'b0;
            next_free_next = clear_code + (CW+1)'(2);
          end else if (is_stop) begin
            prev_valid_next = 1'b0;
            stopped_next = 1'b1;
          end else if (is_known) begin
            add_pend_next = prev_valid && room;
            kwk_next = 1'b0;
            emit_code_next = code_now;
            walk_next = code_now;
            sp_next = '0;
          end else if (prev_valid && room) begin
            // unknown code: walk previous string, append its first byte
            add_pend_next = 1'b1;
            kwk_next = 1'b1;
            emit_code_next = next_free[CW-1:0];
            walk_next = prev_code;
            sp_next = (CW+1)'(1);
          end else begin
            prev_valid_next = 1'b0;
          end
        end else if (!stopped) begin
          bitbuf_next = code_now;
          bitcnt_next = bitcnt_inc;
        end
        if (walk_start) begin
          state_next = S_RD;
        end else if (bit_idx == 3'd7 || stopped) begin
          byte_end = 1'b1;
          state_next = S_IDLE;
        end else begin
          bit_idx_next = bit_idx + 3'd1;
        end
      end
      S_RD: state_next = S_WALK;
      // Follow the chain one entry at a time: read, then use here
      S_WALK: begin
        sp_next = sp + (CW+1)'(1);
        if (!at_root) begin
          walk_next = w_prefix;
          state_next = S_RD;
        end else begin
          if (add_pend) begin
            next_free_next = next_free + (CW+1)'(1);
            if (grow) code_w_next = code_w + WW'(1);
          end
          prev_code_next = emit_code;
          prev_valid_next = 1'b1;
          prev_first_next = walk[7:0];
          add_pend_next = 1'b0;
          state_next = S_PRD;
        end
      end
      S_PRD: state_next = S_POP;
      // Pop stack to output register
      S_POP: begin
        if (pop_fire) begin
          ovalid_next = 1'b1;
          // KwKwK: last byte is the first byte of the previous string
          odata_next.out_byte = (kwk && sp == (CW+1)'(1)) ? prev_first : stack_q;
          odata_next.string_end = (sp == (CW+1)'(1));
          sp_next = sp - (CW+1)'(1);
          if (sp == (CW+1)'(1)) begin
            if (bit_idx == 3'd7) begin
              byte_end = 1'b1;
              state_next = S_IDLE;
            end else begin
              bit_idx_next = bit_idx + 3'd1;
              state_next = S_BITS;
            end
          end else begin
            state_next = S_PRD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Final byte done: back to start values
    if (byte_end && cur_final) begin
      bitbuf_next = '0;
      bitcnt_next = '0;
      code_w_next = WW'(lit_w) + WW'(1);
      prev_code_next = '0;
      prev_valid_next = 1'b0;
      next_free_next = clear_code + (CW+1)'(2);
      stopped_next = 1'b0;
    end

    // Register write restarts decoding at the new width
    if (cfg_we) begin
      lit_w_next = cfg_lw;
      bitbuf_next = '0;
      bitcnt_next = '0;
      code_w_next = WW'(cfg_lw) + WW'(1);
      prev_code_next = '0;
      prev_valid_next = 1'b0;
      next_free_next = ((CW+1)'(1) << cfg_lw) + (CW+1)'(2);
      stopped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lit_w <= LIT_WIDTH_RESET;
      bitbuf <= '0;
      bitcnt <= '0;
      code_w <= WW'(LIT_WIDTH_RESET) + WW'(1);
      prev_code <= '0;
      prev_valid <= 1'b0;
      prev_first <= '0;
      next_free <= ((CW+1)'(1) << LIT_WIDTH_RESET) + (CW+1)'(2);
      stopped <= 1'b0;
      cur_byte <= '0;
      cur_final <= 1'b0;
      bit_idx <= '0;
      walk <= '0;
      sp <= '0;
      add_pend <= 1'b0;
      kwk <= 1'b0;
      emit_code <= '0;
      ovalid <= 1'b0;
      odata <= '0;
    end else begin
      state <= state_next;
      lit_w <= lit_w_next;
      bitbuf <= bitbuf_next;
      bitcnt <= bitcnt_next;
      code_w <= code_w_next;
      prev_code <= prev_code_next;
      prev_valid <= prev_valid_next;
      prev_first <= prev_first_next;
      next_free <= next_free_next;
      stopped <= stopped_next;
      cur_byte <= cur_byte_next;
      cur_final <= cur_final_next;
      bit_idx <= bit_idx_next;
      walk <= walk_next;
      sp <= sp_next;
      add_pend <= add_pend_next;
      kwk <= kwk_next;
      emit_code <= emit_code_next;
      ovalid <= ovalid_next;
      odata <= odata_next;
    end
  end

endmodule
